// ----- rtl/core/dvsg_pkg.sv -----
// dvsg_pkg: widths, derived sizes and the control bundle of the workload governor.
// Standalone package; used by the channel interfaces and by every core module.
package dvsg_pkg;

	// Field widths
	localparam int TICK_W  = 32;
	localparam int PERF_W  = 7;
	localparam int SCALE_W = PERF_W + 1;
	localparam int AVG_W   = 40;

	// Smoothing weight W; averages follow (avg*W + new) / (W + 1)
	localparam int SMOOTH_W = 4;
	localparam int DIV_C    = SMOOTH_W + 1;
	localparam int WGT_W    = $clog2(DIV_C);

	// Serial word length of avg*W + new, and the bit counter that walks it
	localparam int SUM_W = AVG_W + WGT_W + 1;
	localparam int CNT_W = $clog2(SUM_W);

	// Ratio divider: dividend avg_busy*100, one saturation step and PERF_W quotient bits
	localparam int REM_W  = AVG_W + PERF_W;
	localparam int QSTEPS = PERF_W + 1;
	localparam int QCNT_W = $clog2(QSTEPS);

	localparam logic [PERF_W-1:0] PERF_FULL = PERF_W'(100);

	// Phase strobes from the sequencer to each smoothing lane
	typedef struct packed {
		logic clr;
		logic ser;
		logic div;
	} dvsg_ctl_t;

endpackage

// ----- rtl/core/dvsg_if.sv -----
// dvsg_if: valid/ready channels for tick samples and performance requests.
// Depends on dvsg_pkg for the field widths.
interface dvsg_smp_if;
	logic                        valid;
	logic                        ready;
	logic [dvsg_pkg::TICK_W-1:0] system_tick_count;
	logic [dvsg_pkg::TICK_W-1:0] idle_tick_count;
	logic [dvsg_pkg::PERF_W-1:0] current_perf;

	modport source (output valid, output system_tick_count, output idle_tick_count,
		output current_perf, input ready);
	modport sink (input valid, input system_tick_count, input idle_tick_count,
		input current_perf, output ready);
endinterface

interface dvsg_req_if;
	logic                        valid;
	logic                        ready;
	logic [dvsg_pkg::PERF_W-1:0] requested_perf;
	logic                        perf_change;
	logic                        deadline_zero;

	modport source (output valid, output requested_perf, output perf_change,
		output deadline_zero, input ready);
	modport sink (input valid, input requested_perf, input perf_change,
		input deadline_zero, output ready);
endinterface

// ----- rtl/core/dvsg_smooth.sv -----
// dvsg_smooth: one bit-serial smoothing lane, weighting a delta stream and folding it
// into a 40-bit exponential average. Depends on dvsg_pkg.
module dvsg_smooth (
	input  logic                         clk,
	input  logic                         arst_n,
	input  dvsg_pkg::dvsg_ctl_t          ctl,
	input  logic                         delta_bit,
	input  logic [dvsg_pkg::SCALE_W-1:0] scale,
	output logic [dvsg_pkg::AVG_W-1:0]   avg
);
	import dvsg_pkg::*;

	localparam int WACC_W = WGT_W + 1;
	localparam logic [WACC_W-1:0] W_C = WACC_W'(SMOOTH_W);
	localparam logic [WACC_W-1:0] D_C = WACC_W'(DIV_C);

	logic [SCALE_W-1:0] mul_acc_q;
	logic [SCALE_W:0]   mul_sum;
	logic               new_bit;
	logic [WACC_W-1:0]  wacc_q;
	logic [WACC_W:0]    wsum;
	logic [SUM_W-1:0]   sum_q;
	logic [AVG_W-1:0]   avg_q;
	logic [WGT_W-1:0]   rem_q;
	logic [WACC_W-1:0]  trial;
	logic               fits;

	// LSB-first: delta*scale, then avg*W + new; MSB-first: restoring divide by W+1
	always_comb begin
		mul_sum = {1'b0, mul_acc_q} + (delta_bit ? {1'b0, scale} : '0);
		new_bit = mul_sum[0];
		wsum    = {1'b0, wacc_q} + (avg_q[0] ? {1'b0, W_C} : '0)
			+ {{WACC_W{1'b0}}, new_bit};
		trial   = {rem_q, sum_q[SUM_W-1]};
		fits    = (trial >= D_C);
	end

	// Carry and remainder digits: clear per sample, advance per phase
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mul_acc_q <= '0;
			wacc_q    <= '0;
			rem_q     <= '0;
		end else if (ctl.clr) begin
			mul_acc_q <= '0;
			wacc_q    <= '0;
			rem_q     <= '0;
		end else if (ctl.ser) begin
			mul_acc_q <= mul_sum[SCALE_W:1];
			wacc_q    <= wsum[WACC_W:1];
		end else if (ctl.div) begin
			rem_q <= fits ? WGT_W'(trial - D_C) : trial[WGT_W-1:0];
		end
	end

	// Average: shift out LSB-first, then collect quotient bits MSB-first
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			avg_q <= '0;
		end else if (ctl.ser) begin
			avg_q <= {1'b0, avg_q[AVG_W-1:1]};
		end else if (ctl.div) begin
			avg_q <= {avg_q[AVG_W-2:0], fits};
		end
	end

	// Sum word: fill from the top, then drain from the top
	always_ff @(posedge clk) begin
		if (ctl.ser) begin
			sum_q <= {wsum[0], sum_q[SUM_W-1:1]};
		end else if (ctl.div) begin
			sum_q <= {sum_q[SUM_W-2:0], 1'b0};
		end
	end

	assign avg = avg_q;

endmodule

// ----- rtl/core/dvsg_ratio.sv -----
// dvsg_ratio: iterative busy*100/total divider with saturation at 100 percent.
// Depends on dvsg_pkg.
module dvsg_ratio (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [dvsg_pkg::AVG_W-1:0]  busy_w,
	input  logic [dvsg_pkg::AVG_W-1:0]  total_w,
	output logic                        done,
	output logic [dvsg_pkg::PERF_W-1:0] ratio,
	output logic                        zero
);
	import dvsg_pkg::*;

	logic [REM_W-1:0]  rem_q;
	logic [REM_W-1:0]  dv_q;
	logic [QSTEPS-1:0] quo_q;
	logic [QCNT_W-1:0] step_q;
	logic              run_q;
	logic              zero_q;
	logic [REM_W:0]    diff;
	logic              ge;

	// One trial subtraction per step
	always_comb begin
		diff = {1'b0, rem_q} - {1'b0, dv_q};
		ge   = ~diff[REM_W];
	end

	// Step sequencing
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			step_q <= '0;
		end else if (start) begin
			run_q  <= 1'b1;
			step_q <= QCNT_W'(QSTEPS - 1);
		end else if (run_q) begin
			if (step_q == '0) begin
				run_q <= 1'b0;
			end else begin
				step_q <= step_q - QCNT_W'(1);
			end
		end
	end

	// Dividend, shifted divisor and quotient; the first step decides saturation
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q  <= REM_W'(busy_w) * REM_W'(PERF_FULL);
			dv_q   <= {total_w, PERF_W'(0)};
			quo_q  <= '0;
			zero_q <= (total_w == '0);
		end else if (run_q) begin
			if (ge) begin
				rem_q <= diff[REM_W-1:0];
			end
			dv_q  <= dv_q >> 1;
			quo_q <= {quo_q[QSTEPS-2:0], ge};
		end
	end

	assign done  = run_q && (step_q == '0);
	assign ratio = (quo_q[PERF_W] || (quo_q[PERF_W-1:0] > PERF_FULL))
		? PERF_FULL : quo_q[PERF_W-1:0];
	assign zero  = zero_q;

endmodule

// ----- rtl/core/dvs_workload_governor.sv -----
// dvs_workload_governor: workload-driven performance governor, top level.
// Depends on dvsg_pkg, dvsg_if, dvsg_smooth and dvsg_ratio.
//
//  channel   | dir | beat contents
//  ----------+-----+----------------------------------------------------------
//  samples   | in  | system_tick_count, idle_tick_count, current_perf
//  requests  | out | requested_perf, perf_change, deadline_zero
//
// Each sample is worked in turn: the two smoothing lanes run bit-serial, first
// forming avg*W + new LSB-first and then dividing it by W+1 MSB-first, and
// then the ratio divider needs PERF_W+1 steps. One sample is in work at a time.
// A result beat waits in the output register while the next sample is taken.
// Reset clears tick history and both averages to zero.
module dvs_workload_governor (
	input  logic       clk,
	input  logic       arst_n,
	dvsg_smp_if.sink   samples,
	dvsg_req_if.source requests
);
	import dvsg_pkg::*;

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_SER    = 3'd1;
	localparam logic [2:0] ST_DIV    = 3'd2;
	localparam logic [2:0] ST_RSTART = 3'd3;
	localparam logic [2:0] ST_RWAIT  = 3'd4;
	localparam logic [2:0] ST_FIN    = 3'd5;

	logic [2:0]         state_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [TICK_W-1:0]  sys_q;
	logic [TICK_W-1:0]  idle_q;
	logic [TICK_W-1:0]  prev_sys_q;
	logic [TICK_W-1:0]  prev_idle_q;
	logic [PERF_W-1:0]  cur_q;
	logic               bt_q;
	logic               bi_q;
	logic               bb_q;
	logic               vld_q;
	logic [PERF_W-1:0]  req_q;
	logic               chg_q;
	logic               dz_q;

	logic               accept;
	logic               cnt_last;
	logic               lo;
	logic               shift;
	logic               td;
	logic               id;
	logic               bd;
	logic               total_bit;
	logic               busy_bit;
	logic [SCALE_W-1:0] scale;
	dvsg_ctl_t          ctl;
	logic [AVG_W-1:0]   avg_busy;
	logic [AVG_W-1:0]   avg_total;
	logic               r_start;
	logic               r_done;
	logic [PERF_W-1:0]  r_ratio;
	logic               r_zero;
	logic               out_free;
	logic [PERF_W-1:0]  final_perf;

	assign samples.ready = (state_q == ST_IDLE);
	assign accept        = samples.valid && samples.ready;
	assign cnt_last      = (cnt_q == CNT_W'(SUM_W - 1));
	assign lo            = (cnt_q < CNT_W'(TICK_W));
	assign shift         = (state_q == ST_SER) && lo;
	assign scale         = {1'b0, cur_q} + SCALE_W'(1);
	assign r_start       = (state_q == ST_RSTART);
	assign out_free      = !vld_q || requests.ready;

	// Serial wrapping deltas: total, idle, and busy = total - idle
	always_comb begin
		td        = sys_q[0] ^ prev_sys_q[0] ^ bt_q;
		id        = idle_q[0] ^ prev_idle_q[0] ^ bi_q;
		bd        = td ^ id ^ bb_q;
		total_bit = lo && td;
		busy_bit  = lo && bd;
		ctl.clr   = accept;
		ctl.ser   = (state_q == ST_SER);
		ctl.div   = (state_q == ST_DIV);
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					cnt_q <= '0;
					if (accept) begin
						state_q <= ST_SER;
					end
				end
				ST_SER: begin
					if (cnt_last) begin
						cnt_q   <= '0;
						state_q <= ST_DIV;
					end else begin
						cnt_q <= cnt_q + CNT_W'(1);
					end
				end
				ST_DIV: begin
					if (cnt_last) begin
						cnt_q   <= '0;
						state_q <= ST_RSTART;
					end else begin
						cnt_q <= cnt_q + CNT_W'(1);
					end
				end
				ST_RSTART: begin
					state_q <= ST_RWAIT;
				end
				ST_RWAIT: begin
					if (r_done) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Subtractor borrows: clear per sample, advance with the tick bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bt_q <= 1'b0;
			bi_q <= 1'b0;
			bb_q <= 1'b0;
		end else if (accept) begin
			bt_q <= 1'b0;
			bi_q <= 1'b0;
			bb_q <= 1'b0;
		end else if (shift) begin
			bt_q <= (~sys_q[0] & prev_sys_q[0]) | (~(sys_q[0] ^ prev_sys_q[0]) & bt_q);
			bi_q <= (~idle_q[0] & prev_idle_q[0]) | (~(idle_q[0] ^ prev_idle_q[0]) & bi_q);
			bb_q <= (~td & id) | (~(td ^ id) & bb_q);
		end
	end

	// Previous counters: rotate the new snapshot in as the old one leaves
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_sys_q  <= '0;
			prev_idle_q <= '0;
		end else if (shift) begin
			prev_sys_q  <= {sys_q[0], prev_sys_q[TICK_W-1:1]};
			prev_idle_q <= {idle_q[0], prev_idle_q[TICK_W-1:1]};
		end
	end

	// Sample capture and serial shift-out
	always_ff @(posedge clk) begin
		if (accept) begin
			sys_q  <= samples.system_tick_count;
			idle_q <= samples.idle_tick_count;
			cur_q  <= samples.current_perf;
		end else if (shift) begin
			sys_q  <= sys_q >> 1;
			idle_q <= idle_q >> 1;
		end
	end

	dvsg_smooth u_busy (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (ctl),
		.delta_bit (busy_bit),
		.scale     (scale),
		.avg       (avg_busy)
	);

	dvsg_smooth u_total (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (ctl),
		.delta_bit (total_bit),
		.scale     (scale),
		.avg       (avg_total)
	);

	dvsg_ratio u_ratio (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (r_start),
		.busy_w  (avg_busy),
		.total_w (avg_total),
		.done    (r_done),
		.ratio   (r_ratio),
		.zero    (r_zero)
	);

	// Zero deadline keeps the current percent
	assign final_perf = r_zero ? cur_q : r_ratio;

	// Output register: drop a taken beat, load a finished one when free
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if ((state_q == ST_FIN) && out_free) begin
			vld_q <= 1'b1;
		end else if (requests.ready) begin
			vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == ST_FIN) && out_free) begin
			req_q <= final_perf;
			chg_q <= (final_perf != cur_q);
			dz_q  <= r_zero;
		end
	end

	assign requests.valid          = vld_q;
	assign requests.requested_perf = req_q;
	assign requests.perf_change    = chg_q;
	assign requests.deadline_zero  = dz_q;

endmodule
